// ----- design/adc_noise_statistics_unit_macros.svh -----
// Assertion macros used by the statistics unit checker.
`ifndef ADC_NOISE_STATISTICS_UNIT_MACROS_SVH
`define ADC_NOISE_STATISTICS_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ANU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("statistics unit check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ANU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("statistics unit check failed");

`endif

// ----- design/anu_pkg.sv -----
// Package: types and constants of the ADC noise statistics unit.
package anu_pkg;

	localparam int CodeBits = 24;
	localparam int CountBits = 16;
	localparam logic [CountBits-1:0] MaxSamples = 16'hFFFF;

	localparam logic [7:0] RdyBit = 8'h80;
	localparam logic [3:0] ChanMask = 4'hF;

	localparam logic [15:0] SettleReset = 16'd256;
	localparam logic [15:0] WindowReset = 16'd2048;
	localparam logic [3:0] ChannelReset = 4'd3;
	localparam logic [CodeBits-1:0] MinReset = 24'hFFFFFF;

	// Configuration register indexes
	localparam logic [1:0] CfgSettle = 2'd0;
	localparam logic [1:0] CfgWindow = 2'd1;
	localparam logic [1:0] CfgChannel = 2'd2;

	// Outcome codes
	localparam logic [2:0] OutStatusErr = 3'd0;
	localparam logic [2:0] OutNotReady = 3'd1;
	localparam logic [2:0] OutWrongChan = 3'd2;
	localparam logic [2:0] OutDataErr = 3'd3;
	localparam logic [2:0] OutSettling = 3'd4;
	localparam logic [2:0] OutAccum = 3'd5;

	typedef struct packed {
		logic status_read_ok;
		logic [7:0] status_byte;
		logic data_read_ok;
		logic [23:0] raw_code;
	} item_t;

	typedef struct packed {
		logic [2:0] outcome;
		logic window_done;
		logic [15:0] sample_count;
		logic [23:0] code_min;
		logic [23:0] code_max;
		logic [31:0] mean_fixed;
		logic [31:0] std_fixed;
		logic [23:0] peak_to_peak;
		logic [31:0] error_total;
		logic [31:0] ready_total;
	} result_t;

endpackage

// ----- design/adc_noise_statistics_unit.sv -----
// Top level: ADC poll classification and windowed noise statistics.
//
// Usage:
//  - item channel (item_valid/item_ready/item) takes one ADC poll result.
//  - result channel (result_valid/result_ready/result) returns one result per item.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes settle_count (0),
//    window_size (1) and expected_channel (2); cfg_ready is high while no item is
//    being worked on, and a pending write holds item_ready low.
// An item that is not accumulated goes from its transfer through DELIVER to the
// output register; an accumulated item that publishes nothing passes SQR and
// ADD first. A publishing item runs the bit-serial datapath: shift-add multiply
// and mean division in CALC, a subtract in SUB, variance division in the 96-step
// restoring divider in DIV and square root in ROOT. Only one item is in flight
// at a time; the next transfer can follow once the output register loads.
// Reset loads the register defaults and the settle countdown, clears the sample,
// error and ready counters and the sums, and empties the output register. While
// the receiver stalls the result holds in the output register; one further item
// is accepted and worked on meanwhile, and waits in its own holding register
// until the output frees.
module adc_noise_statistics_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  anu_pkg::item_t item,
	output logic result_valid,
	input  logic result_ready,
	output anu_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQR, ST_ADD, ST_LOAD, ST_CALC, ST_SUB, ST_DIV, ST_ROOT, ST_DELIVER
	} state_t;

	state_t state_q;
	logic [15:0] settle_count_q, window_q, settle_left_q, acc_q;
	logic [3:0] channel_q;
	logic [23:0] min_q, max_q, code_q;
	logic [39:0] sum_q;
	logic [63:0] sq_q;
	logic [31:0] err_q, good_q;
	logic grow_q, done_q, result_valid_q;
	anu_pkg::result_t res_q, result_q;
	logic [6:0] cnt_q;

	// Datapath work registers
	logic [47:0] prod_q;
	logic [39:0] na_q, sb_q;
	logic [79:0] acc_a_q, acc_b_q;
	logic [47:0] mdvd_q;
	logic [15:0] mrem_q;
	logic [31:0] mq_q;
	logic [95:0] dvd_q;
	logic [31:0] dsr_q, drem_q;
	logic [63:0] dq_q;
	logic [33:0] rrem_q;
	logic [31:0] root_q;

	// Classify the incoming poll
	logic accept;
	logic [2:0] outc;
	logic is_err, is_good, first, grow, done;
	logic [15:0] acc_new, win;
	logic [23:0] min_new, max_new;
	logic [31:0] err_new, good_new;

	assign item_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign accept = item_valid && item_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_comb begin
		is_err = 1'b0;
		is_good = 1'b0;
		if (!item.status_read_ok) begin
			outc = anu_pkg::OutStatusErr;
			is_err = 1'b1;
		end else if ((item.status_byte & anu_pkg::RdyBit) != 8'd0) begin
			outc = anu_pkg::OutNotReady;
		end else if ((item.status_byte[3:0] & anu_pkg::ChanMask) != channel_q) begin
			outc = anu_pkg::OutWrongChan;
			is_err = 1'b1;
		end else if (!item.data_read_ok) begin
			outc = anu_pkg::OutDataErr;
			is_err = 1'b1;
		end else if (settle_left_q != 16'd0) begin
			outc = anu_pkg::OutSettling;
			is_good = 1'b1;
		end else begin
			outc = anu_pkg::OutAccum;
			is_good = 1'b1;
		end
		first = (acc_q == 16'd0);
		grow = (outc == anu_pkg::OutAccum) && (acc_q != anu_pkg::MaxSamples);
		acc_new = grow ? acc_q + 16'd1 : acc_q;
		min_new = min_q;
		max_new = max_q;
		if (grow) begin
			min_new = (first || item.raw_code < min_q) ? item.raw_code : min_q;
			max_new = (first || item.raw_code > max_q) ? item.raw_code : max_q;
		end
		win = (window_q < 16'd2) ? 16'd2 : window_q;
		done = (outc == anu_pkg::OutAccum) && (acc_new >= win);
		err_new = (is_err && err_q != 32'hFFFFFFFF) ? err_q + 32'd1 : err_q;
		good_new = (is_good && good_q != 32'hFFFFFFFF) ? good_q + 32'd1 : good_q;
	end

	// Serial step logic
	logic [16:0] m_trial;
	logic [32:0] d_trial;
	logic [35:0] r_cur, r_trial;

	always_comb begin
		m_trial = {mrem_q, mdvd_q[47]};
		d_trial = {drem_q, dvd_q[95]};
		r_cur = {rrem_q, dq_q[63:62]};
		r_trial = {2'b00, root_q, 2'b01};
	end

	// Hold state, counters, configuration and the result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			settle_count_q <= anu_pkg::SettleReset;
			settle_left_q <= anu_pkg::SettleReset;
			window_q <= anu_pkg::WindowReset;
			channel_q <= anu_pkg::ChannelReset;
			acc_q <= 16'd0;
			min_q <= anu_pkg::MinReset;
			max_q <= 24'd0;
			sum_q <= 40'd0;
			sq_q <= 64'd0;
			err_q <= 32'd0;
			good_q <= 32'd0;
			grow_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= 7'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					anu_pkg::CfgSettle: begin
						settle_count_q <= cfg_data;
						settle_left_q <= cfg_data;
					end
					anu_pkg::CfgWindow: window_q <= cfg_data;
					anu_pkg::CfgChannel: channel_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (result_valid_q && result_ready && state_q != ST_DELIVER) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						err_q <= err_new;
						good_q <= good_new;
						if (outc == anu_pkg::OutSettling) begin
							settle_left_q <= settle_left_q - 16'd1;
						end
						acc_q <= acc_new;
						min_q <= min_new;
						max_q <= max_new;
						if (grow && first) begin
							sum_q <= 40'd0;
							sq_q <= 64'd0;
						end
						grow_q <= grow;
						done_q <= done;
						state_q <= (outc == anu_pkg::OutAccum) ? ST_SQR : ST_DELIVER;
					end
				end
				ST_SQR: state_q <= ST_ADD;
				ST_ADD: begin
					if (grow_q) begin
						sum_q <= sum_q + {16'd0, code_q};
						sq_q <= sq_q + {16'd0, prod_q};
					end
					state_q <= done_q ? ST_LOAD : ST_DELIVER;
				end
				ST_LOAD: begin
					cnt_q <= 7'd0;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd47) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					cnt_q <= 7'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 7'd95) begin
						cnt_q <= 7'd0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd31) begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Advance the bit-serial datapath and build the result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					code_q <= item.raw_code;
					res_q.outcome <= outc;
					res_q.window_done <= done;
					res_q.sample_count <= acc_new;
					res_q.code_min <= done ? min_new : 24'd0;
					res_q.code_max <= done ? max_new : 24'd0;
					res_q.peak_to_peak <= done ? max_new - min_new : 24'd0;
					res_q.mean_fixed <= 32'd0;
					res_q.std_fixed <= 32'd0;
					res_q.error_total <= err_new;
					res_q.ready_total <= good_new;
				end
			end
			ST_SQR: prod_q <= 48'(code_q) * 48'(code_q);
			ST_ADD: ;
			ST_LOAD: begin
				na_q <= {24'd0, acc_q};
				sb_q <= sum_q;
				acc_a_q <= 80'd0;
				acc_b_q <= 80'd0;
				mdvd_q <= {sum_q, 8'd0};
				mrem_q <= 16'd0;
				mq_q <= 32'd0;
			end
			ST_CALC: begin
				if (cnt_q < 7'd40) begin
					acc_a_q <= {acc_a_q[78:0], 1'b0} + (na_q[39] ? {16'd0, sq_q} : 80'd0);
					acc_b_q <= {acc_b_q[78:0], 1'b0} + (sb_q[39] ? {40'd0, sum_q} : 80'd0);
					na_q <= {na_q[38:0], 1'b0};
					sb_q <= {sb_q[38:0], 1'b0};
				end
				mdvd_q <= {mdvd_q[46:0], 1'b0};
				if (m_trial >= {1'b0, acc_q}) begin
					mrem_q <= 16'(m_trial - {1'b0, acc_q});
					mq_q <= {mq_q[30:0], 1'b1};
				end else begin
					mrem_q <= m_trial[15:0];
					mq_q <= {mq_q[30:0], 1'b0};
				end
			end
			ST_SUB: begin
				dvd_q <= {acc_a_q - acc_b_q, 16'd0};
				dsr_q <= 32'(acc_q) * 32'(acc_q - 16'd1);
				drem_q <= 32'd0;
				dq_q <= 64'd0;
				rrem_q <= 34'd0;
				root_q <= 32'd0;
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[94:0], 1'b0};
				if (d_trial >= {1'b0, dsr_q}) begin
					drem_q <= 32'(d_trial - {1'b0, dsr_q});
					dq_q <= {dq_q[62:0], 1'b1};
				end else begin
					drem_q <= d_trial[31:0];
					dq_q <= {dq_q[62:0], 1'b0};
				end
			end
			ST_ROOT: begin
				dq_q <= {dq_q[61:0], 2'b00};
				if (r_cur >= r_trial) begin
					rrem_q <= 34'(r_cur - r_trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rrem_q <= r_cur[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
				if (cnt_q == 7'd31) begin
					res_q.mean_fixed <= mq_q;
					res_q.std_fixed <= (r_cur >= r_trial) ?
						{root_q[30:0], 1'b1} : {root_q[30:0], 1'b0};
				end
			end
			ST_DELIVER: begin
				if (!result_valid_q || result_ready) begin
					result_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- design/anu_checker.sv -----
// Checker: port-level assertions for the statistics unit, and its bind.
`include "adc_noise_statistics_unit_macros.svh"

module anu_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input anu_pkg::result_t result
);

	// A stalled result stays offered
	`ANU_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid)
	// Published statistics come only from accumulated samples
	`ANU_ASSERT_NOW(a_done_accum, result_valid && result.window_done,
		result.outcome == anu_pkg::OutAccum && result.sample_count >= 16'd2)
	// Spread agrees with the reported extremes
	`ANU_ASSERT_NOW(a_pp, result_valid && result.window_done,
		result.peak_to_peak == result.code_max - result.code_min
		&& result.code_min <= result.code_max)
	// Statistics fields are zero while unpublished
	`ANU_ASSERT_NOW(a_zero, result_valid && !result.window_done,
		result.mean_fixed == 32'd0 && result.std_fixed == 32'd0
		&& result.peak_to_peak == 24'd0)

endmodule

bind adc_noise_statistics_unit anu_checker u_anu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

// ----- test/adc_noise_statistics_unit_test.sv -----
// Testbench for the ADC noise statistics unit: predicted results checked per transfer.
`timescale 1ns / 100ps

module adc_noise_statistics_unit_test;

	// Register index with no register behind it
	localparam logic [1:0] CfgUnused = 2'd3;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	anu_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	anu_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// Predictor copy of the registers and the statistics state
	logic [15:0] reg_window;
	logic [3:0] reg_channel;
	logic [15:0] left_to_settle;
	logic [15:0] n_accum;
	logic [23:0] low_code;
	logic [23:0] high_code;
	logic [39:0] code_sum;
	logic [63:0] square_sum;
	logic [31:0] error_count;
	logic [31:0] good_count;

	anu_pkg::result_t pending_stats[$];
	int send_idle_pct;
	int recv_idle_pct;
	int fail_count;
	int outcome_seen[8];
	int published_count;

	adc_noise_statistics_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Generate the 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] root;
		logic [63:0] b;
		root = '0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= root + b) begin
				x = x - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] bump(logic [31:0] v);
		return (v == 32'hFFFFFFFF) ? v : v + 32'd1;
	endfunction

	// Classify one poll, update the statistics and form the expected result
	task automatic predict_poll(input anu_pkg::item_t p, output anu_pkg::result_t r);
		logic [15:0] win;
		logic [127:0] n;
		logic [127:0] spread;
		logic [127:0] quot;
		r = '0;
		if (!p.status_read_ok) begin
			error_count = bump(error_count);
			r.outcome = anu_pkg::OutStatusErr;
		end else if ((p.status_byte & anu_pkg::RdyBit) != 0) begin
			r.outcome = anu_pkg::OutNotReady;
		end else if ((p.status_byte[3:0] & anu_pkg::ChanMask) != reg_channel) begin
			error_count = bump(error_count);
			r.outcome = anu_pkg::OutWrongChan;
		end else if (!p.data_read_ok) begin
			error_count = bump(error_count);
			r.outcome = anu_pkg::OutDataErr;
		end else begin
			good_count = bump(good_count);
			if (left_to_settle > 0) begin
				left_to_settle = left_to_settle - 16'd1;
				r.outcome = anu_pkg::OutSettling;
			end else begin
				r.outcome = anu_pkg::OutAccum;
				if (n_accum < anu_pkg::MaxSamples) begin
					if (n_accum == 0) begin
						low_code = p.raw_code;
						high_code = p.raw_code;
						code_sum = '0;
						square_sum = '0;
					end
					if (p.raw_code < low_code)
						low_code = p.raw_code;
					if (p.raw_code > high_code)
						high_code = p.raw_code;
					code_sum = code_sum + p.raw_code;
					square_sum = square_sum + 64'(p.raw_code) * 64'(p.raw_code);
					n_accum = n_accum + 16'd1;
				end
				win = (reg_window < 16'd2) ? 16'd2 : reg_window;
				if (n_accum >= win) begin
					n = 128'(n_accum);
					r.window_done = 1'b1;
					r.code_min = low_code;
					r.code_max = high_code;
					r.peak_to_peak = high_code - low_code;
					r.mean_fixed = 32'((64'(code_sum) << 8) / 64'(n_accum));
					spread = (n * 128'(square_sum) - 128'(code_sum) * 128'(code_sum)) << 16;
					quot = spread / (n * (n - 128'd1));
					r.std_fixed = 32'(floor_sqrt(quot[63:0]));
				end
			end
		end
		r.sample_count = n_accum;
		r.error_total = error_count;
		r.ready_total = good_count;
	endtask

	// Offer one poll and hold it until the transfer
	task automatic send_poll(input anu_pkg::item_t p);
		anu_pkg::result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= p;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		predict_poll(p, r);
		pending_stats.push_back(r);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain(input int settle_cycles);
		item_valid <= 1'b0;
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (settle_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		drain(8);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			anu_pkg::CfgSettle: left_to_settle = data;
			anu_pkg::CfgWindow: reg_window = data;
			anu_pkg::CfgChannel: reg_channel = data[3:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic anu_pkg::item_t good_poll(logic [23:0] code);
		anu_pkg::item_t p;
		p.status_read_ok = 1'b1;
		p.status_byte = {1'b0, 3'($urandom_range(7)), reg_channel};
		p.data_read_ok = 1'b1;
		p.raw_code = code;
		return p;
	endfunction

	function automatic anu_pkg::item_t make_poll(logic ok_s, logic [7:0] st, logic ok_d,
		logic [23:0] c);
		anu_pkg::item_t p;
		p.status_read_ok = ok_s;
		p.status_byte = st;
		p.data_read_ok = ok_d;
		p.raw_code = c;
		return p;
	endfunction

	// Compare one field and count the mismatch
	task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
		if (exp !== act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			fail_count++;
		end
	endtask

	// Check each result transfer against the oldest expectation
	always @(posedge clk) begin
		anu_pkg::result_t e;
		if (arst_n && result_valid && result_ready) begin
			if (pending_stats.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				e = pending_stats.pop_front();
				check_field("outcome", e.outcome, result.outcome);
				check_field("window_done", e.window_done, result.window_done);
				check_field("sample_count", e.sample_count, result.sample_count);
				check_field("code_min", e.code_min, result.code_min);
				check_field("code_max", e.code_max, result.code_max);
				check_field("mean_fixed", e.mean_fixed, result.mean_fixed);
				check_field("std_fixed", e.std_fixed, result.std_fixed);
				check_field("peak_to_peak", e.peak_to_peak, result.peak_to_peak);
				check_field("error_total", e.error_total, result.error_total);
				check_field("ready_total", e.ready_total, result.ready_total);
				outcome_seen[e.outcome]++;
				if (e.window_done)
					published_count++;
			end
		end
	end

	// Stall the result channel at random
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Every rejection path and the settling phase under the reset defaults
	task automatic test_default_registers();
		send_poll(make_poll(1'b0, 8'h03, 1'b1, 24'h000000));
		send_poll(make_poll(1'b0, 8'hFF, 1'b0, 24'hFFFFFF));
		send_poll(make_poll(1'b1, 8'h83, 1'b1, 24'h123456));
		send_poll(make_poll(1'b1, 8'hFF, 1'b0, 24'hFFFFFF));
		send_poll(make_poll(1'b1, 8'h0F, 1'b1, 24'hABCDEF));
		send_poll(make_poll(1'b1, 8'h70, 1'b1, 24'h000001));
		send_poll(make_poll(1'b1, 8'h03, 1'b0, 24'h00FFFF));
		send_poll(make_poll(1'b1, 8'h73, 1'b1, 24'hFFFFFF));
		send_poll(make_poll(1'b1, 8'h03, 1'b1, 24'h000000));
	endtask

	// Short settle, window below two, extreme codes and channels
	task automatic test_small_window();
		write_reg(anu_pkg::CfgSettle, 16'd2);
		write_reg(anu_pkg::CfgWindow, 16'd0);
		write_reg(anu_pkg::CfgChannel, 16'd0);
		write_reg(CfgUnused, 16'hFFFF);
		send_poll(good_poll(24'h000000));
		send_poll(good_poll(24'hFFFFFF));
		send_poll(good_poll(24'hFFFFFF));
		send_poll(good_poll(24'h000000));
		send_poll(good_poll(24'h800000));
		write_reg(anu_pkg::CfgWindow, 16'd1);
		write_reg(anu_pkg::CfgChannel, 16'hFFFF);
		send_poll(good_poll(24'hFFFFFF));
		send_poll(make_poll(1'b1, 8'h00, 1'b1, 24'h000000));
		send_poll(good_poll(24'h7FFFFF));
		write_reg(anu_pkg::CfgSettle, 16'hFFFF);
		send_poll(good_poll(24'h555555));
		send_poll(good_poll(24'hAAAAAA));
	endtask

	// Mostly well-formed samples, some around one random level, plus noise polls
	task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
		anu_pkg::item_t p;
		logic [23:0] level;
		drain(8);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		write_reg(anu_pkg::CfgChannel, 16'($urandom_range(15)));
		write_reg(anu_pkg::CfgSettle, 16'($urandom_range(5)));
		write_reg(anu_pkg::CfgWindow, 16'($urandom_range(2, 40)));
		level = 24'($urandom);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 70) begin
				case ($urandom_range(3))
					0: p = good_poll(24'($urandom));
					1: p = good_poll($urandom_range(1) ? 24'hFFFFFF : 24'h000000);
					default: p = good_poll(level + 24'($urandom_range(255)) - 24'd128);
				endcase
			end else begin
				p = anu_pkg::item_t'(34'({$urandom, $urandom}));
				p.status_byte = 8'($urandom);
			end
			send_poll(p);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 34;
		recv_idle_pct = 57;
		fail_count = 0;
		published_count = 0;
		foreach (outcome_seen[k])
			outcome_seen[k] = 0;
		reg_window = anu_pkg::WindowReset;
		reg_channel = anu_pkg::ChannelReset;
		left_to_settle = anu_pkg::SettleReset;
		n_accum = '0;
		low_code = anu_pkg::MinReset;
		high_code = '0;
		code_sum = '0;
		square_sum = '0;
		error_count = '0;
		good_count = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_small_window();
		test_random_traffic(135, 34, 57);
		test_random_traffic(135, 57, 34);
		test_random_traffic(135, 0, 0);
		drain(250);

		$display("Outcomes: status err %0d, not ready %0d, wrong chan %0d, data err %0d",
			outcome_seen[anu_pkg::OutStatusErr], outcome_seen[anu_pkg::OutNotReady],
			outcome_seen[anu_pkg::OutWrongChan], outcome_seen[anu_pkg::OutDataErr]);
		$display("Settling %0d, accumulated %0d, published %0d, final count %0d",
			outcome_seen[anu_pkg::OutSettling], outcome_seen[anu_pkg::OutAccum],
			published_count, n_accum);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#40ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
